[hdl/assert_macros.svh]
// assertion macros shared by the binomial table rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define BMPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define BMPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/bmpf_pkg.sv]
// types and constants of the binomial coefficient table block
// no dependencies
`timescale 1ns / 1ps

package bmpf_pkg;

  localparam int unsigned MOD_W = 31;
  localparam int unsigned IDX_W = 20;
  localparam int unsigned STAT_W = 2;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_BUILT = 2'd2;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_B_MUL = 13'b0000000000010,
    ST_Q_RNK = 13'b0000000000100,
    ST_Q_RK  = 13'b0000000001000,
    ST_Q_CK  = 13'b0000000010000,
    ST_Q_DEN = 13'b0000000100000,
    ST_Q_TOP = 13'b0000001000000,
    ST_P_STP = 13'b0000010000000,
    ST_P_ACC = 13'b0000100000000,
    ST_P_SQR = 13'b0001000000000,
    ST_Q_FIN = 13'b0010000000000,
    ST_DONE  = 13'b0100000000000,
    ST_SPARE = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] a;
    logic [MOD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] result;
  } mul_rsp_t;

endpackage

[hdl/bmpf_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bmpf_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bmpf_modmul.sv]
// modular multiplier: one registered product, then a bit-serial remainder
// depends on bmpf_pkg
`timescale 1ns / 1ps

module bmpf_modmul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bmpf_pkg::MOD_W-1:0]  modulus_i,
  input  bmpf_pkg::mul_req_t          req_i,
  output bmpf_pkg::mul_rsp_t          rsp_o
);

  localparam int unsigned PW = 2 * bmpf_pkg::MOD_W;

  logic [PW-1:0]                prod_q, prod_d;
  logic [bmpf_pkg::MOD_W-1:0]   rem_q, rem_d;
  logic [5:0]                   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [bmpf_pkg::MOD_W:0]     trial;

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, prod_q[PW-1]};
    if (req_i.start) begin
      prod_d = PW'(req_i.a) * PW'(req_i.b);
      rem_d  = '0;
      cnt_d  = 6'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one product bit, subtract once to stay below the modulus
      if (trial >= {1'b0, modulus_i}) begin
        trial = trial - {1'b0, modulus_i};
      end
      rem_d  = trial[bmpf_pkg::MOD_W-1:0];
      prod_d = {prod_q[PW-2:0], 1'b0};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (modulus_i < 31'd2) ? '0 : rem_q;

endmodule

[hdl/binomial_mod_prime_factorial_table.sv]
// Binomial coefficients modulo a configured prime from a table of factorials
// kept in one ram. A build beat walks the table, one modular multiplication per
// entry. A query beat reads three factorials, then runs a square-and-multiply
// Fermat inverse on the one shared bit-serial multiplier. Error queries go
// straight to the done state and put their result out through the output
// register. The next beat is taken while a result still waits at the output
// register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binomial_mod_prime_factorial_table #(
  parameter int unsigned TABLE_SIZE = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bmpf_pkg::MOD_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [bmpf_pkg::IDX_W-1:0]   n_value_i,
  input  logic [bmpf_pkg::IDX_W-1:0]   k_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bmpf_pkg::MOD_W-1:0]   coefficient_o,
  output logic [bmpf_pkg::STAT_W-1:0]  status_o
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned MW = bmpf_pkg::MOD_W;

  bmpf_pkg::state_e   state_q, state_d;
  bmpf_pkg::mul_req_t mul_req;
  bmpf_pkg::mul_rsp_t mul_rsp;

  logic [MW-1:0]                 modulus_q;
  logic                          built_q, built_d;
  logic [AW-1:0]                 idx_q, idx_d;
  logic [bmpf_pkg::IDX_W-1:0]    n_q, n_d, k_q, k_d;
  logic [MW-1:0]                 top_q, top_d, acc_q, acc_d, base_q, base_d;
  logic [MW-1:0]                 exp_q, exp_d;
  logic                          start_q, start_d;
  logic [MW-1:0]                 ma_q, ma_d, mb_q, mb_d;
  logic [MW-1:0]                 res_coef_q, res_coef_d;
  logic [bmpf_pkg::STAT_W-1:0]   res_stat_q, res_stat_d;
  logic                          out_valid_q, out_valid_d;
  logic [MW-1:0]                 coef_q, coef_d;
  logic [bmpf_pkg::STAT_W-1:0]   stat_q, stat_d;
  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [MW-1:0]                 ram_rdata;
  logic [bmpf_pkg::IDX_W-1:0]    n_minus_k;
  logic                          in_beat;
  logic                          mod_ok;

  assign in_beat   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != bmpf_pkg::ST_IDLE);
  assign n_minus_k = n_q - k_q;
  assign mod_ok    = (modulus_q >= 31'd2);

  assign mul_req.start = start_q;
  assign mul_req.a     = ma_q;
  assign mul_req.b     = mb_q;

  bmpf_modmul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (modulus_q),
    .req_i     (mul_req),
    .rsp_o     (mul_rsp)
  );

  assign ram_we = (state_q == bmpf_pkg::ST_B_MUL) && mul_rsp.done;

  bmpf_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (mul_rsp.result),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (state_q)
      bmpf_pkg::ST_Q_RNK: ram_raddr = n_minus_k[AW-1:0];
      bmpf_pkg::ST_Q_RK:  ram_raddr = k_q[AW-1:0];
      default:            ram_raddr = n_value_i[AW-1:0];
    endcase
  end

  always_comb begin
    state_d    = state_q;
    built_d    = built_q;
    idx_d      = idx_q;
    n_d        = n_q;
    k_d        = k_q;
    top_d      = top_q;
    acc_d      = acc_q;
    base_d     = base_q;
    exp_d      = exp_q;
    start_d    = 1'b0;
    ma_d       = ma_q;
    mb_d       = mb_q;
    res_coef_d = res_coef_q;
    res_stat_d = res_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    coef_d     = coef_q;
    stat_d     = stat_q;
    case (state_q)
      bmpf_pkg::ST_IDLE: begin
        if (in_beat) begin
          n_d        = n_value_i;
          k_d        = k_value_i;
          res_coef_d = '0;
          if (kind_i == bmpf_pkg::KIND_BUILD) begin
            idx_d   = '0;
            start_d = 1'b1;
            ma_d    = 31'd1;
            mb_d    = 31'd1;
            state_d = bmpf_pkg::ST_B_MUL;
          end else if (!built_q) begin
            res_stat_d = bmpf_pkg::STATUS_NOT_BUILT;
            state_d    = bmpf_pkg::ST_DONE;
          end else if (({1'b0, n_value_i} >= 21'(TABLE_SIZE)) || (k_value_i > n_value_i)) begin
            res_stat_d = bmpf_pkg::STATUS_RANGE;
            state_d    = bmpf_pkg::ST_DONE;
          end else begin
            state_d = bmpf_pkg::ST_Q_RNK;
          end
        end
      end
      bmpf_pkg::ST_B_MUL: begin
        if (mul_rsp.done) begin
          if (idx_q == AW'(TABLE_SIZE - 1)) begin
            built_d    = 1'b1;
            res_stat_d = bmpf_pkg::STATUS_OK;
            state_d    = bmpf_pkg::ST_DONE;
          end else begin
            idx_d   = idx_q + AW'(1);
            start_d = 1'b1;
            ma_d    = mul_rsp.result;
            mb_d    = MW'(idx_q) + 31'd1;
          end
        end
      end
      bmpf_pkg::ST_Q_RNK: begin
        top_d   = ram_rdata;
        state_d = bmpf_pkg::ST_Q_RK;
      end
      bmpf_pkg::ST_Q_RK: begin
        ma_d    = ram_rdata;
        state_d = bmpf_pkg::ST_Q_CK;
      end
      bmpf_pkg::ST_Q_CK: begin
        mb_d    = ram_rdata;
        start_d = 1'b1;
        state_d = bmpf_pkg::ST_Q_DEN;
      end
      bmpf_pkg::ST_Q_DEN: begin
        if (mul_rsp.done) begin
          base_d  = mul_rsp.result;
          ma_d    = top_q;
          mb_d    = 31'd1;
          start_d = 1'b1;
          state_d = bmpf_pkg::ST_Q_TOP;
        end
      end
      bmpf_pkg::ST_Q_TOP: begin
        if (mul_rsp.done) begin
          top_d   = mul_rsp.result;
          acc_d   = mod_ok ? 31'd1 : 31'd0;
          exp_d   = mod_ok ? modulus_q - 31'd2 : 31'd0;
          state_d = bmpf_pkg::ST_P_STP;
        end
      end
      bmpf_pkg::ST_P_STP: begin
        start_d = 1'b1;
        if (exp_q == '0) begin
          ma_d    = top_q;
          mb_d    = acc_q;
          state_d = bmpf_pkg::ST_Q_FIN;
        end else if (exp_q[0]) begin
          ma_d    = acc_q;
          mb_d    = base_q;
          state_d = bmpf_pkg::ST_P_ACC;
        end else begin
          ma_d    = base_q;
          mb_d    = base_q;
          state_d = bmpf_pkg::ST_P_SQR;
        end
      end
      bmpf_pkg::ST_P_ACC: begin
        if (mul_rsp.done) begin
          acc_d   = mul_rsp.result;
          ma_d    = base_q;
          mb_d    = base_q;
          start_d = 1'b1;
          state_d = bmpf_pkg::ST_P_SQR;
        end
      end
      bmpf_pkg::ST_P_SQR: begin
        if (mul_rsp.done) begin
          base_d  = mul_rsp.result;
          exp_d   = exp_q >> 1;
          state_d = bmpf_pkg::ST_P_STP;
        end
      end
      bmpf_pkg::ST_Q_FIN: begin
        if (mul_rsp.done) begin
          res_coef_d = mul_rsp.result;
          res_stat_d = bmpf_pkg::STATUS_OK;
          state_d    = bmpf_pkg::ST_DONE;
        end
      end
      bmpf_pkg::ST_DONE: begin
        // hand over once the output register is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          coef_d      = res_coef_q;
          stat_d      = res_stat_q;
          state_d     = bmpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmpf_pkg::ST_IDLE;
      built_q     <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      modulus_q   <= bmpf_pkg::MODULUS_RESET;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    top_q      <= top_d;
    acc_q      <= acc_d;
    base_q     <= base_d;
    exp_q      <= exp_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    res_coef_q <= res_coef_d;
    res_stat_q <= res_stat_d;
    coef_q     <= coef_d;
    stat_q     <= stat_d;
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign status_o      = stat_q;

  `BMPF_ASSERT_IMP(a_done_not_idle, mul_rsp.done, state_q != bmpf_pkg::ST_IDLE)
  `BMPF_ASSERT_IMP(a_start_when_free, start_q, !mul_rsp.busy)
  `BMPF_ASSERT_NXT(a_ram_write_build, ram_we, state_q == bmpf_pkg::ST_B_MUL || state_q == bmpf_pkg::ST_DONE)

endmodule

[test/binomial_mod_prime_factorial_table_checker.sv]
// scoreboard for the binomial coefficient table block: watches both channels and the
// modulus register, keeps its own factorial table and counts mismatches
// depends on bmpf_pkg for field widths and status codes
`timescale 1ns / 1ps

module binomial_mod_prime_factorial_table_checker #(
  parameter int unsigned TABLE_SIZE = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bmpf_pkg::MOD_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         kind_i,
  input  logic [bmpf_pkg::IDX_W-1:0]   n_value_i,
  input  logic [bmpf_pkg::IDX_W-1:0]   k_value_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [bmpf_pkg::MOD_W-1:0]   coefficient_i,
  input  logic [bmpf_pkg::STAT_W-1:0]  status_i,
  output int                           mismatches_o,
  output int                           pending_o
);

  typedef struct {
    logic [bmpf_pkg::MOD_W-1:0]  coef;
    logic [bmpf_pkg::STAT_W-1:0] status;
  } binom_result_t;

  logic [bmpf_pkg::MOD_W-1:0] modulus_q;
  logic [bmpf_pkg::MOD_W-1:0] fact_tbl [TABLE_SIZE];
  bit                         tbl_ready;
  binom_result_t              expected_q [$];

  function automatic logic [bmpf_pkg::MOD_W-1:0] mod_mult(longint unsigned a,
                                                          longint unsigned b,
                                                          logic [bmpf_pkg::MOD_W-1:0] m);
    longint unsigned mm;
    mm = m;
    if (m < 2) return '0;
    return bmpf_pkg::MOD_W'((a * b) % mm);
  endfunction

  function automatic logic [bmpf_pkg::MOD_W-1:0] fermat_pow(logic [bmpf_pkg::MOD_W-1:0] base,
                                                            logic [bmpf_pkg::MOD_W-1:0] ex,
                                                            logic [bmpf_pkg::MOD_W-1:0] m);
    logic [bmpf_pkg::MOD_W-1:0] acc;
    logic [bmpf_pkg::MOD_W-1:0] sq;
    acc = mod_mult(1, 1, m);
    sq = mod_mult(base, 1, m);
    while (ex != 0) begin
      if (ex[0]) acc = mod_mult(acc, sq, m);
      sq = mod_mult(sq, sq, m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic binom_result_t predict_binom(logic kind, int unsigned n, int unsigned k);
    binom_result_t r;
    logic [bmpf_pkg::MOD_W-1:0] top;
    logic [bmpf_pkg::MOD_W-1:0] den;
    logic [bmpf_pkg::MOD_W-1:0] inv;
    r.coef = '0;
    r.status = bmpf_pkg::STATUS_OK;
    if (kind == bmpf_pkg::KIND_BUILD) begin
      fact_tbl[0] = mod_mult(1, 1, modulus_q);
      for (int i = 1; i < TABLE_SIZE; i++) fact_tbl[i] = mod_mult(fact_tbl[i-1], i, modulus_q);
      tbl_ready = 1;
    end else if (!tbl_ready) begin
      r.status = bmpf_pkg::STATUS_NOT_BUILT;
    end else if (n >= TABLE_SIZE || k > n) begin
      r.status = bmpf_pkg::STATUS_RANGE;
    end else begin
      top = mod_mult(fact_tbl[n], 1, modulus_q);
      den = mod_mult(fact_tbl[n-k], fact_tbl[k], modulus_q);
      inv = fermat_pow(den, (modulus_q >= 2) ? modulus_q - 2 : '0, modulus_q);
      r.coef = mod_mult(top, inv, modulus_q);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    tbl_ready = 0;
    modulus_q = bmpf_pkg::MODULUS_RESET;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    binom_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) modulus_q <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        expected_q = {expected_q, predict_binom(kind_i, n_value_i, k_value_i)};
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat, coefficient", coefficient_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (coefficient_i !== want.coef) report_mismatch("coefficient", coefficient_i, want.coef);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        end
      end
    end
  end
endmodule

[test/binomial_mod_prime_factorial_table_tb.sv]
// stimulus and verdict for the binomial coefficient table block
// depends on bmpf_pkg, the block and binomial_mod_prime_factorial_table_checker
`timescale 1ns / 1ps

module binomial_mod_prime_factorial_table_tb;

  localparam int unsigned TBL = 4096;
  localparam longint unsigned CYCLE_LIMIT = 40_000_000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic [bmpf_pkg::MOD_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic kind = 0;
  logic [bmpf_pkg::IDX_W-1:0] n_value = '0;
  logic [bmpf_pkg::IDX_W-1:0] k_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [bmpf_pkg::MOD_W-1:0] coefficient;
  logic [bmpf_pkg::STAT_W-1:0] status;
  int mismatches;
  int pending;
  bit quiet = 0;
  longint unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  binomial_mod_prime_factorial_table #(.TABLE_SIZE(TBL)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .kind_i(kind),
    .n_value_i(n_value), .k_value_i(k_value), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .coefficient_o(coefficient), .status_o(status)
  );

  binomial_mod_prime_factorial_table_checker #(.TABLE_SIZE(TBL)) checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .kind_i(kind),
    .n_value_i(n_value), .k_value_i(k_value), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .coefficient_i(coefficient), .status_i(status),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts, none once the run goes quiet
  initial begin
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 20)) @(posedge clk_i) out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 19)) @(posedge clk_i) out_stall <= 1'b1;
      end
    end
  end

  task automatic send_beat(logic kd, logic [bmpf_pkg::IDX_W-1:0] n,
                           logic [bmpf_pkg::IDX_W-1:0] k);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind <= kd;
    n_value <= n;
    k_value <= k;
    do @(posedge clk_i); while (in_stall !== 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_modulus(logic [bmpf_pkg::MOD_W-1:0] m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_query();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      n = $urandom_range(0, TBL - 1);
      send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'(n),
                bmpf_pkg::IDX_W'($urandom_range(0, n)));
    end else if (sel < 85) begin
      n = $urandom_range(0, TBL - 2);
      send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'(n),
                bmpf_pkg::IDX_W'($urandom_range(n + 1, (1 << bmpf_pkg::IDX_W) - 1)));
    end else begin
      send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'($urandom),
                bmpf_pkg::IDX_W'($urandom));
    end
  endtask

  initial begin
    int unsigned mods[] = '{7, 13, 251, 97, 2, 3, 1021, 4, 0, 1, 65521, 11};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // queries before any build
    send_beat(bmpf_pkg::KIND_QUERY, '0, '0);
    send_beat(bmpf_pkg::KIND_QUERY, '1, '1);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd100, 20'd3);
    // build at the reset modulus
    send_beat(bmpf_pkg::KIND_BUILD, '1, '1);
    send_beat(bmpf_pkg::KIND_QUERY, '0, '0);
    send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'(TBL - 1), '0);
    send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'(TBL - 1), bmpf_pkg::IDX_W'(TBL - 1));
    send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'(TBL - 1), bmpf_pkg::IDX_W'(TBL / 2));
    send_beat(bmpf_pkg::KIND_QUERY, 20'd5, 20'd6);
    send_beat(bmpf_pkg::KIND_QUERY, bmpf_pkg::IDX_W'(TBL), '0);
    send_beat(bmpf_pkg::KIND_QUERY, '1, '0);
    // sender holds off until every result is back
    drain_results();
    set_modulus(31'h7fffffff);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd1000, 20'd17);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd40, 20'd20);
    set_modulus(31'd0);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd30, 20'd10);
    send_beat(bmpf_pkg::KIND_BUILD, '0, '0);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd30, 20'd10);
    set_modulus(31'd1);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd3, 20'd1);
    set_modulus(31'd2);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd3, 20'd1);
    send_beat(bmpf_pkg::KIND_QUERY, 20'd0, 20'd0);

    // build from a large prime so smaller moduli reduce stored entries, again at 251
    set_modulus(bmpf_pkg::MODULUS_RESET);
    send_beat(bmpf_pkg::KIND_BUILD, bmpf_pkg::IDX_W'($urandom), bmpf_pkg::IDX_W'($urandom));

    foreach (mods[i]) begin
      set_modulus(bmpf_pkg::MOD_W'(mods[i]));
      if (mods[i] == 251)
        send_beat(bmpf_pkg::KIND_BUILD, bmpf_pkg::IDX_W'($urandom), bmpf_pkg::IDX_W'($urandom));
      if (i == mods.size() - 2) quiet = 1;
      for (int j = 0; j < 150; j++) send_random_query();
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
